@@ hdl/grdfs_pkg.sv @@
// shared constants and types for the depth-first reachability block
package grdfs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = 6;   // bits of a vertex number
    localparam int COUNT_W      = 7;   // bits of a vertex count or stack depth
    localparam int IN_DATA_W    = 88;  // 82 payload bits padded to whole bytes
    localparam int OUT_DATA_W   = 8;   // 6 payload bits padded to whole bytes

    // opcodes carried on the input tuser bit
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [VERT_W-1:0]       vertex_t;
    typedef logic [COUNT_W-1:0]      count_t;
    typedef logic [MAX_VERTICES-1:0] row_t;

endpackage

@@ hdl/graph_reachability_dfs_path.sv @@
// top level of the depth-first reachability block over an adjacency matrix
//
// A load transfer (tuser = 0) writes one 64-bit adjacency row into a 64 x 64 RAM;
// the block is ready again in the next cycle. A query transfer
// (tuser = 1) runs a depth-first search from source to target, trying neighbors in
// rising index order, with the path kept on a 64 x 6 stack RAM. The block is not
// ready during a query. One shared find-first-set unit picks the next neighbor from
// the registered adjacency row masked by the visited marks and the vertex count.
// Each advance to a new vertex goes through row read and select, each backtrack
// through stack read, reload, row read and select, as each RAM has a single read
// port. Each path entry is read from the stack and held on the output until
// m_axis_tready takes it, before the next entry is read. Results are:
// the path from source to target, tuser = 1, tlast on the target; or a single
// transfer with tuser = 0, vertex 0 and tlast when the target is not reached or
// when source or target is not below vertex_count. Querying a row that was never
// loaded gives undefined results. vertex_count above 64 acts as 64.
module graph_reachability_dfs_path
    import grdfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: vertex_count
    input  logic                  cfg_wr_en,
    input  logic [COUNT_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: row_index[5:0], row_bits[69:6], source_vertex[75:70],
    //        target_vertex[81:76], zero pad[87:82]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode
    input  logic                  s_axis_tuser,
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: path_vertex[5:0], zero pad[7:6]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: reachable
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADJ_RD,   // read adjacency row of the top vertex
        ST_EVAL,     // pick next neighbor or backtrack
        ST_POP_RD,   // read new top of stack
        ST_POP_LD,   // take it as the current vertex
        ST_EMIT_RD,  // read one path entry
        ST_OUT       // result waits for transfer
    } state_t;

    state_t  state_reg, state_next;
    count_t  vcount_reg, vcount_next;
    count_t  depth_reg, depth_next;
    vertex_t top_v_reg, top_v_next;
    vertex_t target_reg, target_next;
    row_t    visited_reg, visited_next;
    row_t    valid_reg, valid_next;
    vertex_t emit_idx_reg, emit_idx_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_reach_reg, out_reach_next;
    logic    out_last_reg, out_last_next;

    // memories
    row_t    adj_mem [MAX_VERTICES];
    row_t    adj_rdata_reg;
    vertex_t stack_mem [MAX_VERTICES];
    vertex_t stack_rdata_reg;

    // input fields
    vertex_t in_row_index;
    row_t    in_row_bits;
    vertex_t in_source;
    vertex_t in_target;
    logic    in_xfer;

    // control for the memories
    logic    adj_we;
    logic    stack_we;
    vertex_t stack_waddr;
    vertex_t stack_wdata;
    vertex_t stack_raddr;

    // search datapath
    count_t  n_eff;
    row_t    valid_mask;
    row_t    cand;
    logic    cand_any;
    logic [7:0] grp_nz;
    logic [2:0] grp_sel;
    logic [7:0] grp_bits;
    logic [2:0] bit_sel;
    vertex_t next_w;

    assign in_row_index = s_axis_tdata[5:0];
    assign in_row_bits  = s_axis_tdata[69:6];
    assign in_source    = s_axis_tdata[75:70];
    assign in_target    = s_axis_tdata[81:76];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reach_reg;
    assign m_axis_tlast  = out_last_reg;
    // not-reachable result carries vertex 0
    assign m_axis_tdata  = {2'b00, (out_reach_reg ? stack_rdata_reg : vertex_t'(0))};

    // effective vertex count, saturated at the array size
    assign n_eff = (vcount_reg > count_t'(MAX_VERTICES)) ? count_t'(MAX_VERTICES)
                                                         : vcount_reg;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            valid_mask[i] = (count_t'(i) < n_eff);
        end
    end

    // candidate neighbors: edges into valid, unvisited vertices
    assign cand     = adj_rdata_reg & valid_reg & ~visited_reg;
    assign cand_any = |cand;

    // find-first-set in two levels: lowest nonzero byte, then lowest bit in it
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            grp_nz[g] = |cand[g*8 +: 8];
        end
        grp_sel = 3'd0;
        for (int g = 7; g >= 0; g--) begin
            if (grp_nz[g]) begin
                grp_sel = 3'(g);
            end
        end
        grp_bits = cand[{grp_sel, 3'b000} +: 8];
        bit_sel  = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (grp_bits[b]) begin
                bit_sel = 3'(b);
            end
        end
    end

    assign next_w = {grp_sel, bit_sel};

    // memory control
    assign adj_we = in_xfer && (s_axis_tuser == OP_LOAD);

    always_comb begin
        stack_we    = 1'b0;
        stack_waddr = depth_reg[VERT_W-1:0];
        stack_wdata = next_w;
        if (state_reg == ST_IDLE) begin
            // source goes to the bottom of the stack
            stack_we    = in_xfer && (s_axis_tuser == OP_QUERY);
            stack_waddr = vertex_t'(0);
            stack_wdata = in_source;
        end else if (state_reg == ST_EVAL) begin
            stack_we = cand_any;
        end
    end

    assign stack_raddr = (state_reg == ST_EMIT_RD) ? emit_idx_reg
                                                   : depth_reg[VERT_W-1:0] - vertex_t'(1);

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[in_row_index] <= in_row_bits;
        end
        if (state_reg == ST_ADJ_RD) begin
            adj_rdata_reg <= adj_mem[top_v_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (state_reg == ST_POP_RD || state_reg == ST_EMIT_RD) begin
            stack_rdata_reg <= stack_mem[stack_raddr];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        depth_next     = depth_reg;
        top_v_next     = top_v_reg;
        target_next    = target_reg;
        visited_next   = visited_reg;
        valid_next     = valid_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_reach_next = out_reach_reg;
        out_last_next  = out_last_reg;

        if (cfg_wr_en) begin
            vcount_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_axis_tuser == OP_QUERY) begin
                    valid_next    = valid_mask;
                    target_next   = in_target;
                    top_v_next    = in_source;
                    emit_idx_next = vertex_t'(0);
                    if ({1'b0, in_source} >= n_eff || {1'b0, in_target} >= n_eff) begin
                        // one not-reachable result
                        depth_next     = count_t'(0);
                        visited_next   = row_t'(0);
                        out_valid_next = 1'b1;
                        out_reach_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        depth_next   = count_t'(1);
                        visited_next = row_t'(1) << in_source;
                        state_next   = (in_source == in_target) ? ST_EMIT_RD : ST_ADJ_RD;
                    end
                end
            end
            ST_ADJ_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (cand_any) begin
                    // push the lowest unvisited neighbor
                    visited_next = visited_reg | (row_t'(1) << next_w);
                    depth_next   = depth_reg + count_t'(1);
                    top_v_next   = next_w;
                    state_next   = (next_w == target_reg) ? ST_EMIT_RD : ST_ADJ_RD;
                end else begin
                    // dead end: backtrack
                    depth_next = depth_reg - count_t'(1);
                    if (depth_reg == count_t'(1)) begin
                        out_valid_next = 1'b1;
                        out_reach_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD: begin
                state_next = ST_POP_LD;
            end
            ST_POP_LD: begin
                top_v_next = stack_rdata_reg;
                state_next = ST_ADJ_RD;
            end
            ST_EMIT_RD: begin
                out_valid_next = 1'b1;
                out_reach_next = 1'b1;
                out_last_next  = ({1'b0, emit_idx_reg} + count_t'(1)) == depth_reg;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + vertex_t'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= count_t'(MAX_VERTICES);
            depth_reg     <= count_t'(0);
            visited_reg   <= row_t'(0);
            out_valid_reg <= 1'b0;
            out_reach_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
            out_reach_reg <= out_reach_next;
            out_last_reg  <= out_last_next;
        end
        top_v_reg    <= top_v_next;
        target_reg   <= target_next;
        valid_reg    <= valid_next;
        emit_idx_reg <= emit_idx_next;
    end

endmodule

@@ hdl/grdfs_checker.sv @@
// port-level checker for the depth-first reachability block, with its bind
module grdfs_checker
    import grdfs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // no new item is taken while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // a not-reachable result is always the only and last one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("not-reachable result malformed");

    // a query transfer makes the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
        else $error("ready after query transfer");

    // a row load keeps the block ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD) |=> s_axis_tready)
        else $error("not ready after row load");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind graph_reachability_dfs_path grdfs_checker u_grdfs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
